// ===== rtl/core/sapt_pkg.sv =====
// Shared types, widths and codes for the stepper angle position tracker.
// Used by sapt_muldiv and stepper_angle_position_tracker_unit.
package sapt_pkg;

	localparam int PositionBitsDef = 24;

	localparam int OpW      = 3;
	localparam int EvW      = 3;
	localparam int ValW     = 32;
	localparam int SprW     = 24;
	localparam int AuptW    = 22;
	localparam int ChunkW   = 24;
	localparam int FreqW    = 31;
	localparam int AngW     = 22;
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 24;

	localparam int MulAW = 32;
	localparam int MulBW = 24;
	localparam int NumW  = MulAW + MulBW + 2;
	localparam int DivW  = MulBW + 1;
	localparam int CntW  = $clog2(NumW);

	localparam logic [OpW-1:0] OP_ROTATE  = 3'd0;
	localparam logic [OpW-1:0] OP_PREP    = 3'd1;
	localparam logic [OpW-1:0] OP_DONE    = 3'd2;
	localparam logic [OpW-1:0] OP_ESTOP   = 3'd3;
	localparam logic [OpW-1:0] OP_RECOVER = 3'd4;
	localparam logic [OpW-1:0] OP_TEST    = 3'd5;

	localparam logic [EvW-1:0] EV_NONE     = 3'd0;
	localparam logic [EvW-1:0] EV_PREPARE  = 3'd1;
	localparam logic [EvW-1:0] EV_COMPLETE = 3'd2;
	localparam logic [EvW-1:0] EV_START    = 3'd3;
	localparam logic [EvW-1:0] EV_RECOVER  = 3'd4;

	localparam logic [CfgIdxW-1:0] CFG_SPR   = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_AUPT  = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_CHUNK = 2'd2;

	typedef struct packed {
		logic             start;
		logic [MulAW-1:0] a;
		logic [MulBW-1:0] b;
		logic [MulBW-1:0] d;
	} md_req_t;

	typedef struct packed {
		logic            done;
		logic [NumW-1:0] quot;
	} md_rsp_t;

endpackage

// ===== rtl/core/sapt_muldiv.sv =====
// Shared multiply and round-half-up divide unit: floor((2*a*b + d) / (2*d)).
// One multiply, one add, then a restoring divider one quotient bit per cycle.
// Depends on sapt_pkg.
module sapt_muldiv (
	input  logic              clk,
	input  logic              arst_n,
	input  sapt_pkg::md_req_t req,
	output sapt_pkg::md_rsp_t rsp
);
	import sapt_pkg::*;

	typedef enum logic [3:0] {
		M_IDLE = 4'b0001,
		M_MUL  = 4'b0010,
		M_ADD  = 4'b0100,
		M_DIV  = 4'b1000
	} md_state_t;

	md_state_t              state_q;
	logic [CntW-1:0]        cnt_q;
	logic                   done_q;
	logic [MulAW-1:0]       a_q;
	logic [MulBW-1:0]       b_q;
	logic [MulBW-1:0]       d_q;
	logic [MulAW+MulBW-1:0] prod_q;
	logic [NumW-1:0]        num_q;
	logic [DivW-1:0]        rem_q;

	logic [DivW-1:0] dvs;
	logic [DivW:0]   trial;
	logic [DivW:0]   diff;
	logic            ge;
	logic [DivW-1:0] rem_nxt;

	assign dvs     = {d_q, 1'b0};
	assign trial   = {rem_q, num_q[NumW-1]};
	assign ge      = trial >= {1'b0, dvs};
	assign diff    = trial - {1'b0, dvs};
	assign rem_nxt = ge ? diff[DivW-1:0] : trial[DivW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				M_IDLE: begin
					if (req.start) state_q <= M_MUL;
				end
				M_MUL: state_q <= M_ADD;
				M_ADD: begin
					cnt_q   <= '0;
					state_q <= M_DIV;
				end
				M_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CntW'(NumW - 1)) begin
						done_q  <= 1'b1;
						state_q <= M_IDLE;
					end
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			M_IDLE: begin
				if (req.start) begin
					a_q <= req.a;
					b_q <= req.b;
					d_q <= req.d;
				end
			end
			M_MUL: prod_q <= a_q * b_q;
			M_ADD: begin
				num_q <= {prod_q, 1'b0} + NumW'(d_q);
				rem_q <= '0;
			end
			M_DIV: begin
				num_q <= {num_q[NumW-2:0], ge};
				rem_q <= rem_nxt;
			end
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.quot = num_q;

endmodule

// ===== rtl/core/stepper_angle_position_tracker_unit.sv =====
// Stepper angle position tracker: one motor event in, one state snapshot out.
// Each result passes through the shared 58-iteration restoring divider in sapt_muldiv, and a taken
// rotation request passes through it twice. A new item is accepted only once the previous result is
// loaded into the output register, which waits while out_stall holds a result that is still shown.
// Reset (arst_n, asynchronous, active low): flags, position and plan clear, registers
// return to 3200 / 3600 / 200. Depends on sapt_pkg and sapt_muldiv.
module stepper_angle_position_tracker_unit #(
	parameter int POSITION_BITS = sapt_pkg::PositionBitsDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [sapt_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [sapt_pkg::CfgDataW-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [sapt_pkg::OpW-1:0]      opcode,
	input  logic                          payload_is_signed,
	input  logic signed [sapt_pkg::ValW-1:0] event_value,
	input  logic [sapt_pkg::SprW-1:0]     steps_done,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [sapt_pkg::EvW-1:0]      event_code,
	output logic [sapt_pkg::ChunkW-1:0]   move_steps,
	output logic                          move_reverse,
	output logic                          test_mode,
	output logic [sapt_pkg::FreqW-1:0]    test_frequency,
	output logic [sapt_pkg::SprW-1:0]     position_steps,
	output logic [sapt_pkg::AngW-1:0]     shaft_angle,
	output logic                          busy_res,
	output logic                          prepared
);
	import sapt_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_EXEC  = 6'b000010,
		S_CONV  = 6'b000100,
		S_ANGLE = 6'b001000,
		S_AWAIT = 6'b010000,
		S_EMIT  = 6'b100000
	} seq_state_t;

	seq_state_t state_q;

	logic [SprW-1:0]   spr_q;
	logic [AuptW-1:0]  aupt_q;
	logic [ChunkW-1:0] chunk_q;

	logic [OpW-1:0]  op_q;
	logic            sgn_q;
	logic [ValW-1:0] val_q;
	logic [SprW-1:0] made_q;

	logic [POSITION_BITS-1:0] pos_q;
	logic                     busy_q;
	logic                     prep_q;
	logic [ChunkW-1:0]        plan_steps_q;
	logic                     plan_rev_q;
	logic                     test_q;
	logic [FreqW-1:0]         freq_q;
	logic [EvW-1:0]           code_q;
	logic [AngW-1:0]          angle_q;

	logic                out_valid_q;
	logic [EvW-1:0]      out_code_q;
	logic [ChunkW-1:0]   out_steps_q;
	logic                out_rev_q;
	logic                out_test_q;
	logic [FreqW-1:0]    out_freq_q;
	logic [SprW-1:0]     out_pos_q;
	logic [AngW-1:0]     out_angle_q;
	logic                out_busy_q;
	logic                out_prep_q;

	md_req_t md_req;
	md_rsp_t md_rsp;

	logic                     in_acc;
	logic                     emit_load;
	logic [SprW-1:0]          spr_eff;
	logic [AuptW-1:0]         aupt_eff;
	logic                     neg;
	logic [ValW-1:0]          mag;
	logic                     rot_go;
	logic                     test_go;
	logic [SprW-1:0]          made_c;
	logic [32:0]              pos_x;
	logic [32:0]              pos_sum;
	logic [32:0]              pos_mv;
	logic [POSITION_BITS-1:0] pos_nxt;
	logic [FreqW-1:0]         freq_sat;
	logic [ChunkW-1:0]        steps_sat;
	logic [AngW-1:0]          angle_sat;
	logic                     steps_zero;

	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = state_q != S_IDLE;
	assign emit_load = (state_q == S_EMIT) && (!out_valid_q || !out_stall);

	assign spr_eff  = (spr_q == '0) ? SprW'(1) : spr_q;
	assign aupt_eff = (aupt_q == '0) ? AuptW'(1) : aupt_q;

	assign neg     = val_q[ValW-1];
	assign mag     = neg ? (~val_q + 1'b1) : val_q;
	assign rot_go  = !busy_q && sgn_q;
	assign test_go = !busy_q && sgn_q;

	// wrap the position forward or back within one turn
	assign made_c  = (made_q > spr_eff) ? spr_eff : made_q;
	assign pos_x   = 33'(pos_q);
	assign pos_sum = pos_x + 33'(made_c);
	always_comb begin
		if (plan_rev_q) begin
			if (33'(made_c) > pos_x) pos_mv = 33'(spr_eff) - (33'(made_c) - pos_x);
			else pos_mv = pos_x - 33'(made_c);
		end else begin
			if (pos_sum >= 33'(spr_eff)) pos_mv = pos_sum - 33'(spr_eff);
			else pos_mv = pos_sum;
		end
	end
	assign pos_nxt = POSITION_BITS'(pos_mv);

	assign freq_sat   = mag[ValW-1] ? '1 : mag[FreqW-1:0];
	assign steps_zero = md_rsp.quot == '0;
	assign steps_sat  = (|md_rsp.quot[NumW-1:ChunkW]) ? '1 : md_rsp.quot[ChunkW-1:0];
	assign angle_sat  = (|md_rsp.quot[NumW-1:AngW]) ? '1 : md_rsp.quot[AngW-1:0];

	always_comb begin
		md_req.start = ((state_q == S_EXEC) && (op_q == OP_ROTATE) && rot_go)
			|| (state_q == S_ANGLE);
		if (state_q == S_ANGLE) begin
			md_req.a = MulAW'(pos_q);
			md_req.b = MulBW'(aupt_eff);
			md_req.d = MulBW'(spr_eff);
		end else begin
			md_req.a = mag;
			md_req.b = MulBW'(spr_eff);
			md_req.d = MulBW'(aupt_eff);
		end
	end

	sapt_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spr_q   <= SprW'(3200);
			aupt_q  <= AuptW'(3600);
			chunk_q <= ChunkW'(200);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_SPR:   spr_q   <= cfg_data;
				CFG_AUPT:  aupt_q  <= cfg_data[AuptW-1:0];
				CFG_CHUNK: chunk_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q   <= opcode;
			sgn_q  <= payload_is_signed;
			val_q  <= event_value;
			made_q <= steps_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pos_q        <= '0;
			busy_q       <= 1'b0;
			prep_q       <= 1'b0;
			plan_steps_q <= '0;
			plan_rev_q   <= 1'b0;
			test_q       <= 1'b0;
			freq_q       <= '0;
			code_q       <= EV_NONE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) state_q <= S_EXEC;
				end
				S_EXEC: begin
					code_q  <= EV_NONE;
					state_q <= S_ANGLE;
					case (op_q)
						OP_ROTATE: begin
							if (rot_go) state_q <= S_CONV;
						end
						OP_PREP: begin
							if (prep_q && !busy_q) begin
								busy_q <= 1'b1;
								code_q <= EV_START;
							end
						end
						OP_DONE: begin
							pos_q  <= pos_nxt;
							busy_q <= 1'b0;
							prep_q <= 1'b0;
						end
						OP_ESTOP: begin
							busy_q <= 1'b0;
							prep_q <= 1'b0;
						end
						OP_RECOVER: begin
							pos_q  <= '0;
							code_q <= EV_RECOVER;
						end
						OP_TEST: begin
							if (test_go) begin
								busy_q       <= 1'b0;
								prep_q       <= 1'b1;
								plan_steps_q <= chunk_q;
								plan_rev_q   <= !neg && (val_q != '0);
								test_q       <= 1'b1;
								freq_q       <= freq_sat;
								code_q       <= EV_PREPARE;
							end
						end
						default: ;
					endcase
				end
				S_CONV: begin
					if (md_rsp.done) begin
						busy_q  <= 1'b0;
						test_q  <= 1'b0;
						freq_q  <= '0;
						state_q <= S_ANGLE;
						if (steps_zero) begin
							prep_q       <= 1'b0;
							plan_steps_q <= '0;
							plan_rev_q   <= 1'b0;
							code_q       <= EV_COMPLETE;
						end else begin
							prep_q       <= 1'b1;
							plan_steps_q <= steps_sat;
							plan_rev_q   <= neg;
							code_q       <= EV_PREPARE;
						end
					end
				end
				S_ANGLE: state_q <= S_AWAIT;
				S_AWAIT: begin
					if (md_rsp.done) state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_AWAIT) && md_rsp.done) angle_q <= angle_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_code_q  <= code_q;
			out_steps_q <= plan_steps_q;
			out_rev_q   <= plan_rev_q;
			out_test_q  <= test_q;
			out_freq_q  <= freq_q;
			out_pos_q   <= SprW'(pos_q);
			out_angle_q <= angle_q;
			out_busy_q  <= busy_q;
			out_prep_q  <= prep_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign event_code     = out_code_q;
	assign move_steps     = out_steps_q;
	assign move_reverse   = out_rev_q;
	assign test_mode      = out_test_q;
	assign test_frequency = out_freq_q;
	assign position_steps = out_pos_q;
	assign shaft_angle    = out_angle_q;
	assign busy_res       = out_busy_q;
	assign prepared       = out_prep_q;

	a_acc_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == S_EXEC)
		else $error("accepted item did not start execution");

	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		md_rsp.done |-> (state_q == S_CONV || state_q == S_AWAIT))
		else $error("divider finished with no conversion pending");

	a_busy_prep: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> prep_q)
		else $error("busy without a prepared move");

	a_out_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_EMIT))
		else $error("result shown outside the emit step");

endmodule
